@@ hdl/ndps_pkg.sv @@
// shared constants and types for the nearest depth pixel search
package ndps_pkg;

    // coordinate and depth widths
    localparam int DIM_BITS   = 12;
    localparam int DEPTH_BITS = 16;
    localparam int REG_BITS   = 13;

    // largest legal frame dimension and the no-reading marker
    localparam logic [REG_BITS-1:0]   DIM_LIMIT = REG_BITS'(1 << DIM_BITS);
    localparam logic [DIM_BITS-1:0]   DIM_MASK  = {DIM_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // register reset values
    localparam logic [REG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = 13'd480;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // last column and last row of the frame, from the configuration
    typedef struct packed {
        logic [DIM_BITS-1:0] last_col;
        logic [DIM_BITS-1:0] last_row;
    } ndps_dims_t;

endpackage

@@ hdl/ndps_cfg.sv @@
// configuration registers and effective frame dimensions
module ndps_cfg
    import ndps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output ndps_dims_t   dims
);

    logic [REG_BITS-1:0] width_reg;
    logic [REG_BITS-1:0] height_reg;
    logic                wr_en;
    logic                reg_sel;

    // zero counts as one, anything above the limit saturates
    function automatic logic [DIM_BITS-1:0] last_index(input logic [REG_BITS-1:0] r);
        logic [REG_BITS-1:0] dec;
        dec = r - REG_BITS'(1);
        if (r == '0)
            last_index = '0;
        else if (r > DIM_LIMIT)
            last_index = DIM_MASK;
        else
            last_index = dec[DIM_BITS-1:0];
    endfunction

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_WIDTH:  width_reg  <= pwdata[REG_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[REG_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_WIDTH:  prdata = {{(32-REG_BITS){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32-REG_BITS){1'b0}}, height_reg};
            default:    prdata = '0;
        endcase
    end

    assign dims.last_col = last_index(width_reg);
    assign dims.last_row = last_index(height_reg);

endmodule

@@ hdl/nearest_depth_pixel_search.sv @@
// Nearest depth pixel search: takes one depth sample per clock in raster order and, on the
// last pixel of each frame, reports the smallest nonzero depth with its column and row.
// Each sample is folded into the running minimum and the pixel counters in the cycle it is
// accepted, so the sustained rate is one sample per clock. The frame result sits in an
// output register; the input stalls only when that result is still untaken and the next
// sample would end another frame. A frame with no valid pixel reports depth 65535, found low
// and the coordinates of the last frame that had one. Frame size is read through the APB
// port (width at 0x0, height at 0x4) and should be changed only between frames.
module nearest_depth_pixel_search
    import ndps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DEPTH_BITS-1:0] depth_sample,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DIM_BITS-1:0]   closest_column,
    output logic [DIM_BITS-1:0]   closest_row,
    output logic [DEPTH_BITS-1:0] closest_depth,
    output logic                  found,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    ndps_dims_t dims;

    logic [DIM_BITS-1:0]   col_reg,       col_next;
    logic [DIM_BITS-1:0]   row_reg,       row_next;
    logic [DEPTH_BITS-1:0] best_depth_reg, best_depth_next;
    logic [DIM_BITS-1:0]   best_col_reg,  best_col_next;
    logic [DIM_BITS-1:0]   best_row_reg,  best_row_next;
    logic                  found_reg,     found_next;

    logic                  out_valid_reg;
    logic [DIM_BITS-1:0]   res_col_reg;
    logic [DIM_BITS-1:0]   res_row_reg;
    logic [DEPTH_BITS-1:0] res_depth_reg;
    logic                  res_found_reg;

    logic in_accept;
    logic out_take;
    logic end_col;
    logic end_frame;
    logic better;

    ndps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // frame position, independent of the sample value
    assign end_col   = col_reg >= dims.last_col;
    assign end_frame = end_col && (row_reg >= dims.last_row);

    // hold off only a frame end that would overwrite an untaken result
    assign in_stall  = out_valid_reg && out_stall && end_frame;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign better = (depth_sample != '0) && (depth_sample < best_depth_reg);

    // running minimum and counters
    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        best_depth_next = best_depth_reg;
        best_col_next   = best_col_reg;
        best_row_next   = best_row_reg;
        found_next      = found_reg;
        if (better)
        begin
            best_depth_next = depth_sample;
            best_col_next   = col_reg;
            best_row_next   = row_reg;
            found_next      = 1'b1;
        end
        if (end_frame)
        begin
            best_depth_next = DEPTH_MAX;
            found_next      = 1'b0;
            col_next        = '0;
            row_next        = '0;
        end
        else if (end_col)
        begin
            col_next = '0;
            row_next = row_reg + DIM_BITS'(1);
        end
        else
        begin
            col_next = col_reg + DIM_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            best_depth_reg <= DEPTH_MAX;
            best_col_reg   <= '0;
            best_row_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            best_depth_reg <= best_depth_next;
            best_col_reg   <= best_col_next;
            best_row_reg   <= best_row_next;
            found_reg      <= found_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept && end_frame)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    // result payload, includes the pixel of this transaction
    always_ff @(posedge clk)
    begin
        if (in_accept && end_frame)
        begin
            res_col_reg   <= better ? col_reg : best_col_reg;
            res_row_reg   <= better ? row_reg : best_row_reg;
            res_depth_reg <= better ? depth_sample : best_depth_reg;
            res_found_reg <= better || found_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign closest_column = res_col_reg;
    assign closest_row    = res_row_reg;
    assign closest_depth  = res_depth_reg;
    assign found          = res_found_reg;

`ifndef ASSERT_OFF
    // a frame end never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_frame |-> !(out_valid_reg && out_stall))
        else $error("frame result overwritten before it was taken");

    // the minimum is cleared after every frame end
    a_min_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_frame |=> !found_reg && best_depth_reg == DEPTH_MAX)
        else $error("running minimum not cleared at frame end");

    // the found flag tracks whether the minimum holds a real reading
    a_found_matches: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg == (best_depth_reg != DEPTH_MAX))
        else $error("found flag disagrees with running minimum");

    // a reported hit always carries a nonzero depth
    a_found_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_found_reg |-> res_depth_reg != '0 && res_depth_reg != DEPTH_MAX)
        else $error("found result with an invalid depth");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the nearest depth pixel search: frame prediction, checking and stimulus
module tb_top
    import ndps_pkg::*;
();

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int LARGE_ITEMS   = 300;
    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_PCT      = 20;

    typedef struct packed {
        logic [DIM_BITS-1:0]   col;
        logic [DIM_BITS-1:0]   row;
        logic [DEPTH_BITS-1:0] depth;
        logic                  hit;
    } frame_result_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic [DEPTH_BITS-1:0] depth_sample = '0;
    logic                  out_stall    = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [2:0]            paddr        = '0;
    logic [31:0]           pwdata       = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic [DIM_BITS-1:0]   closest_column;
    logic [DIM_BITS-1:0]   closest_row;
    logic [DEPTH_BITS-1:0] closest_depth;
    logic                  found;
    logic [31:0]           prdata;
    logic                  pready;

    nearest_depth_pixel_search u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .depth_sample   (depth_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .closest_column (closest_column),
        .closest_row    (closest_row),
        .closest_depth  (closest_depth),
        .found          (found),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #CLK_HALF clk = ~clk;

    // predicted copy of the configuration and the search state
    logic [REG_BITS-1:0]   cfg_width   = WIDTH_RESET;
    logic [REG_BITS-1:0]   cfg_height  = HEIGHT_RESET;
    logic [DIM_BITS-1:0]   col_cnt     = '0;
    logic [DIM_BITS-1:0]   row_cnt     = '0;
    logic [DEPTH_BITS-1:0] best_depth  = DEPTH_MAX;
    logic [DIM_BITS-1:0]   best_col    = '0;
    logic [DIM_BITS-1:0]   best_row    = '0;
    logic                  found_flag  = 1'b0;

    frame_result_t pending_frames[$];
    int            error_count   = 0;
    int            cycle_count   = 0;
    int            send_idle_pct = IDLE_PCT;
    int            recv_idle_pct = IDLE_PCT;
    bit            hold_req      = 1'b0;
    int            hold_left     = 0;

    // register value to frame dimension: zero reads as one, large values saturate
    function automatic int unsigned eff_dim(input logic [REG_BITS-1:0] r);
        if (r == '0)
            return 1;
        if (r > DIM_LIMIT)
            return DIM_LIMIT;
        return r;
    endfunction

    // fold one accepted sample into the running minimum; returns 1 at frame end
    function automatic bit fold_sample(input logic [DEPTH_BITS-1:0] s);
        int unsigned last_col;
        int unsigned last_row;
        bit          end_col;
        bit          end_frame;
        last_col = eff_dim(cfg_width) - 1;
        last_row = eff_dim(cfg_height) - 1;
        if (s != '0 && s < best_depth)
        begin
            best_depth = s;
            best_col   = col_cnt;
            best_row   = row_cnt;
            found_flag = 1'b1;
        end
        end_col   = col_cnt >= last_col;
        end_frame = end_col && row_cnt >= last_row;
        if (end_frame)
        begin
            pending_frames.push_back('{col: best_col, row: best_row,
                                       depth: best_depth, hit: found_flag});
            best_depth = DEPTH_MAX;
            found_flag = 1'b0;
            col_cnt    = '0;
            row_cnt    = '0;
        end
        else if (end_col)
        begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
        end
        return end_frame;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // result transaction check and receiver back-pressure
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("unexpected result: column %0d row %0d depth %0d found %0d",
                       closest_column, closest_row, closest_depth, found);
                error_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("closest_column", want.col, closest_column);
                check_field("closest_row", want.row, closest_row);
                check_field("closest_depth", want.depth, closest_depth);
                check_field("found", want.hit, found);
            end
        end
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // apb write then read back, each a setup phase then an access phase
    task automatic write_register(input logic idx, input logic [REG_BITS-1:0] value,
                                  input bit noisy);
        logic [31:0] data;
        data = $urandom();
        if (!noisy)
            data = '0;
        data[REG_BITS-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", 32'(value), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
    endtask

    task automatic write_dims(input logic [REG_BITS-1:0] w, input logic [REG_BITS-1:0] h,
                              input bit noisy);
        write_register(REG_WIDTH, w, noisy);
        write_register(REG_HEIGHT, h, noisy);
    endtask

    // one sample transaction, with random idle cycles ahead of it
    task automatic send_sample(input logic [DEPTH_BITS-1:0] d, output bit frame_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        depth_sample <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_end = fold_sample(d);
    endtask

    // stop offering and wait for every predicted frame result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // depth mix: no reading, all ones, near all ones, small values for ties, full range
    function automatic logic [DEPTH_BITS-1:0] gen_depth();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return '0;
        if (pick < 20)
            return DEPTH_MAX;
        if (pick < 25)
            return DEPTH_MAX - 1'b1;
        if (pick < 40)
            return DEPTH_BITS'($urandom_range(1, 8));
        return DEPTH_BITS'($urandom());
    endfunction

    // mostly tiny dimensions, sometimes zero, sometimes a bit larger
    function automatic logic [REG_BITS-1:0] rand_dim(input int unsigned tiny,
                                                     input int unsigned big);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 80)
            return REG_BITS'($urandom_range(1, tiny));
        return REG_BITS'($urandom_range(tiny + 1, big));
    endfunction

    // reset size, then frames shrunk while the counters are past the new last index
    task automatic test_reset_dims_mid_frame();
        bit done;
        // empty start under the reset size: coordinates still zero
        send_sample('0, done);
        send_sample(DEPTH_MAX, done);
        send_sample('0, done);
        wait_drained();
        write_dims(13'd3, 13'd1, 1'b0);
        // column counter beyond the new last column: frame ends here
        send_sample('0, done);
        wait_drained();
        write_dims(13'd2, 13'd4, 1'b0);
        repeat (6)
            send_sample(gen_depth(), done);
        wait_drained();
        // row counter beyond the new last row: frame ends on the next last column
        write_register(REG_HEIGHT, 13'd2, 1'b0);
        repeat (2)
            send_sample(gen_depth(), done);
        wait_drained();
    endtask

    // one-pixel frames from zero registers, ties, all ones and empty frames
    task automatic test_single_pixel_frames();
        bit done;
        write_dims('0, '0, 1'b0);
        send_sample('0, done);
        send_sample(DEPTH_MAX, done);
        send_sample(16'd1, done);
        send_sample('0, done);
        send_sample(DEPTH_MAX - 1'b1, done);
        send_sample(16'h8000, done);
        wait_drained();
        write_dims(13'd4, 13'd1, 1'b0);
        // earliest of equal depths wins
        send_sample(16'd7, done);
        send_sample(16'd7, done);
        send_sample(16'd3, done);
        send_sample(16'd3, done);
        // empty frame keeps the previous coordinates
        repeat (4)
            send_sample('0, done);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering one-pixel frames
    task automatic test_output_hold_off();
        bit done;
        write_dims(13'd1, 13'd1, 1'b0);
        send_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (40)
            send_sample(gen_depth(), done);
        wait_drained();
        send_idle_pct = IDLE_PCT;
    endtask

    // oversized registers saturate; the frame is then shrunk so the counter ends it
    task automatic test_largest_frames();
        bit done;
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 0)
                write_dims(13'd4097, 13'd1, 1'b0);
            else
                write_dims(13'd1, 13'h1fff, 1'b0);
            for (int i = 0; i < LARGE_ITEMS; i++)
            begin
                if (i == 100)
                    send_sample('0, done);
                else
                    send_sample(DEPTH_BITS'($urandom_range(100, 65535)), done);
            end
            wait_drained();
            if (pass == 0)
                write_register(REG_WIDTH, 13'd4, 1'b0);
            else
                write_register(REG_HEIGHT, 13'd2, 1'b0);
            // counter past the new last index: this pixel ends the frame as its minimum
            send_sample(16'd2, done);
            wait_drained();
        end
    endtask

    // random frame sizes and content, some frames cut short and resized
    task automatic test_random_frames();
        int items;
        int sent;
        int cut;
        bit done;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            // long stretch without idling on either side
            if (items > 300 && items < 800)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = IDLE_PCT;
                recv_idle_pct = IDLE_PCT;
            end
            write_dims(rand_dim(6, 24), rand_dim(5, 12), 1'b1);
            cut  = ($urandom_range(99) < 15) ? $urandom_range(1, 8) : 0;
            sent = 0;
            done = 1'b0;
            while (!done && (cut == 0 || sent < cut))
            begin
                send_sample(gen_depth(), done);
                sent++;
            end
            items += sent;
            wait_drained();
        end
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_dims_mid_frame();
        test_single_pixel_frames();
        test_output_hold_off();
        test_largest_frames();
        test_random_frames();
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending_frames.size() != 0)
        begin
            $error("%0d frame results never arrived", pending_frames.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
